// ----- hw/rtl/hsd_pkg.sv -----
package hsd_pkg;

	localparam int MAX_BITS = 64;
	localparam int LEN_W    = 7;
	localparam int SYN_W    = 7;
	localparam int DATA_W   = 57;
	localparam int COUNT_W  = 6;
	localparam int LEN_MIN  = 3;

	localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(7);

	typedef logic [LEN_W-1:0]    len_t;
	typedef logic [MAX_BITS-1:0] word_t;
	typedef logic [SYN_W-1:0]    syn_t;
	typedef logic [DATA_W-1:0]   data_t;
	typedef logic [COUNT_W-1:0]  count_t;

	typedef enum logic [1:0] {
		STATUS_NONE      = 2'd0,
		STATUS_CORRECTED = 2'd1,
		STATUS_BEYOND    = 2'd2
	} status_t;

	typedef struct packed {
		word_t   corrected_word;
		syn_t    syndrome;
		status_t status;
		data_t   data_bits;
		count_t  data_count;
	} result_t;

	// Clamp the programmed length to the supported range.
	function automatic len_t sat_len(input len_t raw);
		len_t r;
		r = raw;
		if (raw < LEN_W'(LEN_MIN)) begin
			r = LEN_W'(LEN_MIN);
		end else if (raw > LEN_W'(MAX_BITS)) begin
			r = LEN_W'(MAX_BITS);
		end
		return r;
	endfunction

	function automatic word_t len_mask(input len_t len);
		word_t m;
		for (int k = 0; k < MAX_BITS; k++) begin
			m[k] = (LEN_W'(k) < len);
		end
		return m;
	endfunction

	// Positions that take part in parity check j: those with bit j set.
	function automatic word_t col_mask(input int j);
		word_t m;
		for (int k = 0; k < MAX_BITS; k++) begin
			m[k] = (((k + 1) >> j) & 1) != 0;
		end
		return m;
	endfunction

	// Gathers the non-power-of-two positions, lowest position first. The index
	// of each bit is fixed at elaboration, so this is pure wiring.
	function automatic data_t pack_data(input word_t w);
		data_t d;
		int    n;
		d = '0;
		n = 0;
		for (int p = 1; p <= MAX_BITS; p++) begin
			if ((p & (p - 1)) != 0) begin
				if (n < DATA_W) begin
					d[n] = w[p-1];
				end
				n++;
			end
		end
		return d;
	endfunction

	// Data positions = length minus the powers of two up to the length.
	function automatic count_t data_count(input len_t len);
		len_t npow;
		npow = '0;
		for (int j = 0; j < LEN_W; j++) begin
			if (len >= LEN_W'(1 << j)) begin
				npow = npow + LEN_W'(1);
			end
		end
		return COUNT_W'(len - npow);
	endfunction

endpackage

// ----- hw/rtl/hsd_codeword_if.sv -----
interface hsd_codeword_if
	import hsd_pkg::*;
();
	logic  valid;
	logic  ready;
	word_t received_word;

	modport source (output valid, output received_word, input ready);
	modport sink   (input valid, input received_word, output ready);
endinterface

// ----- hw/rtl/hsd_result_if.sv -----
interface hsd_result_if
	import hsd_pkg::*;
();
	logic       valid;
	logic       ready;
	word_t      corrected_word;
	syn_t       syndrome;
	logic [1:0] status;
	data_t      data_bits;
	count_t     data_count;

	modport source (output valid, output corrected_word, output syndrome, output status,
		output data_bits, output data_count, input ready);
	modport sink   (input valid, input corrected_word, input syndrome, input status,
		input data_bits, input data_count, output ready);
endinterface

// ----- hw/rtl/hamming_sec_decoder.sv -----
// A codeword accepted into the input register moves on into the result register
// as soon as that stage can take it; the result register drives the result port.
// Throughput: one codeword per cycle while the result side is ready; the two
// registers form a two-stage pipeline with ready passed back combinationally.
// Reset: arst_n, asynchronous and active low, empties both stages and sets
// code_length to 7. No clearing pass is needed.
module hamming_sec_decoder
	import hsd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [LEN_W-1:0]     cfg_wdata,
	hsd_codeword_if.sink         codeword,
	hsd_result_if.source         result
);

	// The raw register value is kept; the clamp to 3..64 is applied on the way
	// into the first stage.
	len_t    code_length_q;
	len_t    len_eff;

	logic    v_s1;
	word_t   word_s1;
	len_t    len_s1;

	logic    v_s2;
	result_t res_s2;

	logic    ready_s2;
	syn_t    syn;
	result_t res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_length_q <= LEN_RESET;
		end else if (cfg_we) begin
			code_length_q <= cfg_wdata;
		end
	end

	assign len_eff = sat_len(code_length_q);

	// The result stage can take a beat when it is empty or its beat leaves now.
	// The input stage can take a beat when it is empty or moves into the result
	// stage in the same cycle; a waiting result blocks the input once that is full.
	assign ready_s2       = !v_s2 || result.ready;
	assign codeword.ready = !v_s1 || ready_s2;

	// Stage 1: register the codeword with the unused positions cleared, so that
	// every later step uses the length only for the range compare and data count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (codeword.ready) begin
			v_s1 <= codeword.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (codeword.valid && codeword.ready) begin
			word_s1 <= codeword.received_word & len_mask(len_eff);
			len_s1  <= len_eff;
		end
	end

	// Between the stages: seven parity trees give the syndrome, then a single
	// compare against the length decides whether one bit is flipped. Data bit
	// extraction is fixed wiring.
	hsd_syndrome u_syndrome (
		.word (word_s1),
		.syn  (syn)
	);

	hsd_fix u_fix (
		.word (word_s1),
		.syn  (syn),
		.len  (len_s1),
		.res  (res)
	);

	// Stage 2: the result register drives the output channel directly.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (ready_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1 && ready_s2) begin
			res_s2 <= res;
		end
	end

	assign result.valid          = v_s2;
	assign result.corrected_word = res_s2.corrected_word;
	assign result.syndrome       = res_s2.syndrome;
	assign result.status         = res_s2.status;
	assign result.data_bits      = res_s2.data_bits;
	assign result.data_count     = res_s2.data_count;

`ifndef ASSERT_OFF
	a_none_zero_syn: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && (res_s2.status == STATUS_NONE) |-> (res_s2.syndrome == '0))
		else $error("status none with a nonzero syndrome");

	a_fix_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && (res.status == STATUS_CORRECTED) |->
		(syn != '0) && (syn <= len_s1) && (res.corrected_word != word_s1))
		else $error("correction outside the codeword length");

	a_stage_advance: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && ready_s2 |=> v_s2)
		else $error("beat lost between stages");

	a_stage_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !ready_s2 |=> v_s1 && $stable(word_s1) && $stable(len_s1))
		else $error("stalled first stage was overwritten");
`endif

endmodule

// ----- hw/rtl/hsd_syndrome.sv -----
module hsd_syndrome
	import hsd_pkg::*;
(
	input  word_t word,
	output syn_t  syn
);

	// Each syndrome bit is the parity over the positions that carry that bit.
	for (genvar j = 0; j < SYN_W; j++) begin : g_check
		assign syn[j] = ^(word & col_mask(j));
	end

endmodule

// ----- hw/rtl/hsd_fix.sv -----
module hsd_fix
	import hsd_pkg::*;
(
	input  word_t   word,
	input  syn_t    syn,
	input  len_t    len,
	output result_t res
);

	syn_t    syn_m1;
	word_t   flip;
	status_t status;
	word_t   fixed;

	assign syn_m1 = syn - SYN_W'(1);

	always_comb begin
		flip   = '0;
		status = STATUS_NONE;
		priority if (syn == '0) begin
			status = STATUS_NONE;
		end else if (syn <= len) begin
			status = STATUS_CORRECTED;
			flip[syn_m1[$clog2(MAX_BITS)-1:0]] = 1'b1;
		end else begin
			status = STATUS_BEYOND;
		end
	end

	assign fixed = word ^ flip;

	always_comb begin
		res.corrected_word = fixed;
		res.syndrome       = syn;
		res.status         = status;
		res.data_bits      = pack_data(fixed);
		res.data_count     = data_count(len);
	end

endmodule

// ----- tb/hamming_sec_decoder_test.sv -----
module hamming_sec_decoder_test;
	import hsd_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// The run is ended by force when the cycle counter reaches this limit, which a
	// correct run never reaches, even with every stall the sides can throw at it.
	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_PHASES = 16;
	localparam int WORDS_PER_PHASE = 71;
	localparam int REPORT_CAP = 40;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	len_t cfg_wdata;

	hsd_codeword_if cw_bus();
	hsd_result_if   res_bus();

	hamming_sec_decoder u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.codeword  (cw_bus),
		.result    (res_bus)
	);

	// 12 ns period: six high, six low.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Words waiting to be offered, and the decodes the block owes us, oldest first.
	word_t   codewords_to_send[$];
	result_t expected_decodes[$];

	// Our copy of the length register, updated only while the block is empty.
	len_t length_reg = LEN_RESET;

	int  cycle_count;
	int  words_accepted;
	int  words_checked;
	int  mismatches;
	int  status_tally[3];
	int  settings_used = 1;
	bit  word_taken;
	int  hold_left;
	bit  hold_done;

	// The programmed length saturates to the range the block supports.
	function automatic int eff_len(input len_t raw);
		if (raw < LEN_MIN) begin
			return LEN_MIN;
		end
		if (raw > MAX_BITS) begin
			return MAX_BITS;
		end
		return int'(raw);
	endfunction

	// Expected decode of one received word under a given length setting. The
	// syndrome is the XOR of every in-range position that holds a one; a syndrome
	// inside the length names the bit to flip, one beyond it is only flagged.
	function automatic result_t decode_word(input word_t rx, input len_t raw);
		result_t r;
		word_t   w;
		int      len;
		int      syn;
		int      n;
		len = eff_len(raw);
		w = rx;
		for (int k = len; k < MAX_BITS; k++) begin
			w[k] = 1'b0;
		end
		syn = 0;
		for (int p = 1; p <= len; p++) begin
			if (w[p-1]) begin
				syn = syn ^ p;
			end
		end
		r.syndrome = syn_t'(syn);
		if (syn == 0) begin
			r.status = STATUS_NONE;
		end else if (syn <= len) begin
			r.status = STATUS_CORRECTED;
			w[syn-1] = ~w[syn-1];
		end else begin
			r.status = STATUS_BEYOND;
		end
		// Data bits are the positions that are not powers of two, lowest first.
		r.data_bits = '0;
		n = 0;
		for (int p = 1; p <= len; p++) begin
			if ((p & (p - 1)) != 0) begin
				if (n < DATA_W) begin
					r.data_bits[n] = w[p-1];
				end
				n++;
			end
		end
		r.corrected_word = w;
		r.data_count = count_t'(n);
		return r;
	endfunction

	// Builds a valid codeword of the given effective length with random data, then
	// flips the requested number of in-range bits. Random junk may be added above
	// the length, where the block must ignore it.
	function automatic word_t make_codeword(input int len, input int flips);
		word_t w;
		word_t junk;
		int    syn;
		int    p;
		w = {$urandom, $urandom};
		for (int k = 0; k < MAX_BITS; k++) begin
			if (k >= len || ((k + 1) & k) == 0) begin
				w[k] = 1'b0;
			end
		end
		syn = 0;
		for (int k = 0; k < len; k++) begin
			if (w[k]) begin
				syn = syn ^ (k + 1);
			end
		end
		// Each set syndrome bit j is cancelled by the parity bit at position 2**j,
		// which always lies inside the length.
		for (int j = 0; j < SYN_W; j++) begin
			if (syn[j]) begin
				w[(1 << j) - 1] = 1'b1;
			end
		end
		for (int i = 0; i < flips; i++) begin
			p = $urandom_range(len, 1);
			w[p-1] = ~w[p-1];
		end
		if ($urandom_range(1, 0) == 1) begin
			junk = {$urandom, $urandom};
			w = w | (junk << len);
		end
		return w;
	endfunction

	// Mostly well-formed codewords with zero, one or two errors; the rest are raw
	// random words and words with a single bit set or a single bit clear.
	function automatic word_t random_codeword(input int len);
		word_t w;
		int    pick;
		pick = $urandom_range(99, 0);
		if (pick < 25) begin
			w = make_codeword(len, 0);
		end else if (pick < 65) begin
			w = make_codeword(len, 1);
		end else if (pick < 80) begin
			w = make_codeword(len, 2);
		end else if (pick < 92) begin
			w = {$urandom, $urandom};
		end else begin
			w = '0;
			w[$urandom_range(MAX_BITS - 1, 0)] = 1'b1;
			if (pick >= 96) begin
				w = ~w;
			end
		end
		return w;
	endfunction

	// Both sides run without idling for a stretch in the middle of the run.
	function automatic bit in_steady_stretch();
		return words_accepted >= 600 && words_accepted < 780;
	endfunction

	task automatic note_mismatch(input string field, input logic [63:0] want,
		input logic [63:0] got);
		mismatches++;
		if (mismatches <= REPORT_CAP) begin
			$display("%0t: %s expected %h, got %h", $realtime, field, want, got);
		end
	endtask

	task automatic check_decode(input result_t want, input result_t got);
		if (got.corrected_word !== want.corrected_word) begin
			note_mismatch("corrected_word", want.corrected_word, got.corrected_word);
		end
		if (got.syndrome !== want.syndrome) begin
			note_mismatch("syndrome", 64'(want.syndrome), 64'(got.syndrome));
		end
		if (got.status !== want.status) begin
			note_mismatch("status", 64'(want.status), 64'(got.status));
		end
		if (got.data_bits !== want.data_bits) begin
			note_mismatch("data_bits", 64'(want.data_bits), 64'(got.data_bits));
		end
		if (got.data_count !== want.data_count) begin
			note_mismatch("data_count", 64'(want.data_count), 64'(got.data_count));
		end
	endtask

	// Everything is sampled on the rising edge. The result side is checked before
	// the new word is predicted, so a result can never be matched against the
	// expectation of the word that was taken at the same edge.
	always @(posedge clk) begin
		result_t got;
		cycle_count++;
		if (arst_n && res_bus.valid && res_bus.ready) begin
			if (expected_decodes.size() == 0) begin
				mismatches++;
				$display("%0t: result beat with no decode expected, word %h", $realtime,
					res_bus.corrected_word);
			end else begin
				got.corrected_word = res_bus.corrected_word;
				got.syndrome = res_bus.syndrome;
				got.status = status_t'(res_bus.status);
				got.data_bits = res_bus.data_bits;
				got.data_count = res_bus.data_count;
				status_tally[expected_decodes[0].status]++;
				check_decode(expected_decodes.pop_front(), got);
				words_checked++;
			end
		end
		word_taken = arst_n && cw_bus.valid && cw_bus.ready;
		if (word_taken) begin
			expected_decodes.push_back(decode_word(cw_bus.received_word, length_reg));
			words_accepted++;
		end
	end

	// Sender: changes on the falling edge. A word once offered stays put until it
	// is taken; otherwise the next word goes out unless this cycle is an idle one.
	always @(negedge clk) begin
		if (arst_n && (!cw_bus.valid || word_taken)) begin
			if (codewords_to_send.size() != 0
				&& (in_steady_stretch() || $urandom_range(99, 0) >= 24)) begin
				cw_bus.received_word <= codewords_to_send.pop_front();
				cw_bus.valid <= 1'b1;
			end else begin
				cw_bus.valid <= 1'b0;
			end
		end
	end

	// Receiver: idles at random, and once, with plenty of words still queued up,
	// holds ready low for a long stretch so the pipeline fills and pushes back on
	// the sender.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!hold_done && words_accepted >= 250 && codewords_to_send.size() >= 30) begin
				hold_done = 1'b1;
				hold_left = 64;
			end
			if (hold_left != 0) begin
				hold_left--;
				res_bus.ready <= 1'b0;
			end else begin
				res_bus.ready <= in_steady_stretch() || $urandom_range(99, 0) >= 24;
			end
		end
	end

	// Waits until every queued word has gone in and every decode has come out, then
	// lets the two pipeline stages settle before anything else happens.
	task automatic drain();
		do begin
			@(negedge clk);
		end while (codewords_to_send.size() != 0 || expected_decodes.size() != 0
			|| cw_bus.valid);
		repeat (3) @(negedge clk);
	endtask

	// Length writes only happen with the block empty, so no word in flight can see
	// the setting change under it.
	task automatic write_length(input len_t value);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		length_reg = value;
		settings_used++;
	endtask

	initial begin
		cycle_count = 0;
		wait (cycle_count >= CYCLE_LIMIT);
		$display("%0t: run timed out after %0d cycles", $realtime, cycle_count);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		len_t phase_lengths[RANDOM_PHASES];
		int   len;
		phase_lengths = '{7, 3, 64, 1, 12, 33, 127, 16, 0, 31, 63, 57, 100, 5, 32, 64};
		phase_lengths[4] = len_t'($urandom_range(MAX_BITS, LEN_MIN));
		phase_lengths[12] = len_t'($urandom_range(127, 0));

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		cw_bus.valid = 1'b0;
		cw_bus.received_word = '0;
		res_bus.ready = 1'b0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		// Directed words at the reset length of seven: all zeros, all ones with the
		// upper bits to be ignored, a single error in the first and the last
		// position, a double error that aliases to position three, a clean word.
		codewords_to_send.push_back(64'h0);
		codewords_to_send.push_back({MAX_BITS{1'b1}});
		codewords_to_send.push_back(64'h1);
		codewords_to_send.push_back(64'h40);
		codewords_to_send.push_back(64'h3);
		codewords_to_send.push_back(make_codeword(7, 0));

		// Full 64-bit length: extremes, and an error in the top position.
		write_length(len_t'(MAX_BITS));
		codewords_to_send.push_back(64'h0);
		codewords_to_send.push_back({MAX_BITS{1'b1}});
		codewords_to_send.push_back(64'h8000_0000_0000_0000);
		codewords_to_send.push_back(make_codeword(MAX_BITS, 1));

		// A length below the minimum saturates to three.
		write_length(len_t'(0));
		codewords_to_send.push_back({MAX_BITS{1'b1}});
		codewords_to_send.push_back(64'h4);

		// A length above the maximum saturates to 64; positions one and 64 give a
		// syndrome of 65, beyond the length.
		write_length(len_t'(127));
		codewords_to_send.push_back(64'h8000_0000_0000_0001);

		// Length five: positions three and four give syndrome seven, beyond it.
		write_length(len_t'(5));
		codewords_to_send.push_back(64'h0C);
		codewords_to_send.push_back(64'h1F);

		// Random phases, one length setting each. The drain inside each length
		// write is where the sender pauses for every decode to come back.
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			write_length(phase_lengths[ph]);
			len = eff_len(phase_lengths[ph]);
			for (int i = 0; i < WORDS_PER_PHASE; i++) begin
				codewords_to_send.push_back(random_codeword(len));
			end
		end

		drain();
		repeat (8) @(negedge clk);
		if (expected_decodes.size() != 0) begin
			mismatches++;
			$display("%0t: %0d decodes never came out", $realtime, expected_decodes.size());
		end

		$display("Decoded %0d words over %0d length settings, %0d mismatches.",
			words_checked, settings_used, mismatches);
		$display("Clean words %0d, corrected %0d, syndrome beyond length %0d.",
			status_tally[STATUS_NONE], status_tally[STATUS_CORRECTED],
			status_tally[STATUS_BEYOND]);
		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

// ----- files.f -----
hw/rtl/hsd_pkg.sv
hw/rtl/hsd_codeword_if.sv
hw/rtl/hsd_result_if.sv
hw/rtl/hsd_syndrome.sv
hw/rtl/hsd_fix.sv
hw/rtl/hamming_sec_decoder.sv
tb/hamming_sec_decoder_test.sv
